[sv/csfs_pkg.sv]
// Shared constants, request types and basis-weight functions of the cubic spline frame sampler.
package csfs_pkg;

	// Default upper bound of the samples taken per curve segment.
	localparam int MAX_SAMPLES_DEF = 16;

	// Datapath widths.
	localparam int PW   = 32;  // Q16.16 coordinate
	localparam int UW   = 16;  // Q2.14 unit-vector component
	localparam int ACCW = 64;  // multiply-accumulate register
	localparam int DNW  = 48;  // divider numerator and quotient
	localparam int DDW  = 32;  // divider denominator
	localparam int CW   = 18;  // basis coefficient

	localparam logic signed [UW-1:0] ONE_Q14 = 16'sd16384;

	// Configuration register indexes.
	localparam logic [0:0] REG_CURVE_KIND = 1'd0;
	localparam logic [0:0] REG_SAMPLES    = 1'd1;
	localparam logic [4:0] SAMPLES_RST    = 5'd8;

	// Result kinds.
	localparam logic [1:0] KIND_POS = 2'd0;
	localparam logic [1:0] KIND_TAN = 2'd1;
	localparam logic [1:0] KIND_NRM = 2'd2;
	localparam logic [1:0] KIND_BIN = 2'd3;

	typedef struct packed {
		logic           start;
		logic [DNW-1:0] num;
		logic [DDW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            start;
		logic [ACCW-1:0] rad;
	} sqrt_req_t;

	// Basis weight (deriv = 0) or derivative weight (deriv = 1) of control point p
	// for sample j of s, scaled to integers.
	function automatic logic signed [CW-1:0] basis_coef(input logic bspl, input logic deriv,
		input logic [1:0] p, input logic [4:0] jv, input logic [4:0] sv);
		int j;
		int s;
		int u;
		int r;
		j = int'(jv);
		s = int'(sv);
		u = s - j;
		r = 0;
		if (bspl) begin
			if (!deriv) begin
				case (p)
					2'd0: r = u * u * u;
					2'd1: r = 4 * s * s * s - 6 * j * j * s + 3 * j * j * j;
					2'd2: r = s * s * s + 3 * j * s * s + 3 * j * j * s - 3 * j * j * j;
					default: r = j * j * j;
				endcase
			end else begin
				case (p)
					2'd0: r = -(u * u);
					2'd1: r = -4 * j * s + 3 * j * j;
					2'd2: r = s * s + 2 * j * s - 3 * j * j;
					default: r = j * j;
				endcase
			end
		end else begin
			if (!deriv) begin
				case (p)
					2'd0: r = u * u * u;
					2'd1: r = 3 * j * u * u;
					2'd2: r = 3 * j * j * u;
					default: r = j * j * j;
				endcase
			end else begin
				case (p)
					2'd0: r = -(u * u);
					2'd1: r = u * u - 2 * j * u;
					2'd2: r = 2 * j * u - j * j;
					default: r = j * j;
				endcase
			end
		end
		return CW'(r);
	endfunction

	// Common scale of the position weights.
	function automatic logic [14:0] seg_den(input logic bspl, input logic [4:0] sv);
		int s;
		int r;
		s = int'(sv);
		r = s * s * s;
		if (bspl) begin
			r = 6 * r;
		end
		return 15'(r);
	endfunction

	// Next component index, wrapping z back to x.
	function automatic logic [1:0] nxt3(input logic [1:0] c);
		return (c == 2'd2) ? 2'd0 : c + 2'd1;
	endfunction

endpackage

[sv/csfs_mul.sv]
// Shared signed multiplier with a registered product.
module csfs_mul import csfs_pkg::*; (
	input  logic                   clk,
	input  logic signed [PW-1:0]   a,
	input  logic signed [PW-1:0]   b,
	output logic signed [2*PW-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[sv/csfs_div.sv]
// Restoring unsigned divider that retires one quotient bit per cycle.
module csfs_div import csfs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  div_req_t       req,
	output logic           done_q,
	output logic [DNW-1:0] quo_q
);

	localparam int NCW = $clog2(DNW);

	logic           busy_q;
	logic [NCW-1:0] cnt_q;
	logic [DNW-1:0] num_q;
	logic [DDW-1:0] den_q;
	logic [DDW-1:0] rem_q;
	logic [DDW:0]   rem_sh;
	logic [DDW+1:0] diff;

	assign rem_sh = {rem_q, num_q[DNW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= NCW'(DNW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DNW-2:0], 1'b0};
			quo_q <= {quo_q[DNW-2:0], ~diff[DDW+1]};
			rem_q <= diff[DDW+1] ? rem_sh[DDW-1:0] : diff[DDW-1:0];
		end
	end

endmodule

[sv/csfs_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module csfs_sqrt import csfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sqrt_req_t         req,
	output logic              done_q,
	output logic [ACCW/2-1:0] root_q
);

	localparam int RW  = ACCW / 2;
	localparam int RCW = $clog2(RW);

	logic            busy_q;
	logic [RCW-1:0]  cnt_q;
	logic [ACCW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW+3:0]   rem_sh;
	logic [RW+3:0]   trial;
	logic [RW+4:0]   diff;

	assign rem_sh = {rem_q, rad_q[ACCW-1:ACCW-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign diff   = {1'b0, rem_sh} - {1'b0, trial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= RCW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[ACCW-3:0], 2'b00};
			if (!diff[RW+4]) begin
				rem_q  <= diff[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

endmodule

[sv/cubic_spline_frame_sampler.sv]
// Top level of the cubic spline frame sampler: control-point window, sequencer and datapath.
// A point that finishes no segment is taken with no result; one that finishes a segment runs
// every sample, its time set by output stalls, three position divisions, up to three square
// roots, up to nine unit-vector divisions and one-bit-per-cycle normalizing shifts. One point
// is handled at a time, the next taken once the last result is in the output register. Reset
// (arst_n low) clears all state at once but the divider, root and multiplier data registers.
module cubic_spline_frame_sampler import csfs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	// Control point requests.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	input  logic [0:0]  s_axis_tuser,   // curve_start [0]
	// Result requests.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // comp_x [31:0], comp_y [63:32], comp_z [95:64]
	output logic [1:0]  m_axis_tuser,   // vector_kind [1:0]
	output logic        m_axis_tlast    // last_of_run
);

	localparam int SW    = $clog2(MAX_SAMPLES + 1);
	localparam int WIN_N = 12;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WGT    = 4'd1;
	localparam logic [3:0] S_MAC    = 4'd2;
	localparam logic [3:0] S_DRAIN  = 4'd3;
	localparam logic [3:0] S_MACEND = 4'd4;
	localparam logic [3:0] S_PDIVW  = 4'd5;
	localparam logic [3:0] S_NABS   = 4'd6;
	localparam logic [3:0] S_NSHIFT = 4'd7;
	localparam logic [3:0] S_NSQRT  = 4'd8;
	localparam logic [3:0] S_NDIV   = 4'd9;
	localparam logic [3:0] S_NDIVW  = 4'd10;
	localparam logic [3:0] S_NFIN   = 4'd11;
	localparam logic [3:0] S_EMIT   = 4'd12;

	// Multiply-accumulate operations.
	localparam logic [2:0] OP_POS = 3'd0;  // weighted sum of points for a position
	localparam logic [2:0] OP_TAN = 3'd1;  // derivative sum for the tangent
	localparam logic [2:0] OP_CRN = 3'd2;  // previous binormal cross tangent
	localparam logic [2:0] OP_CRB = 3'd3;  // tangent cross normal
	localparam logic [2:0] OP_SQ  = 3'd4;  // sum of squares for the length

	// Where a normalized vector goes.
	localparam logic [1:0] DST_T = 2'd0;
	localparam logic [1:0] DST_N = 2'd1;
	localparam logic [1:0] DST_B = 2'd2;

	logic [3:0]               state_q;
	logic [2:0]               op_q;
	logic [1:0]               comp_q;
	logic [1:0]               term_q;
	logic [1:0]               dst_q;
	logic [1:0]               emit_k_q;
	logic [SW-1:0]            j_q;
	logic                     kind_q;
	logic [4:0]               samples_q;
	logic [2:0]               held_q;
	logic                     seeded_q;
	logic                     pneg_q;
	logic                     mac_v_s1;
	logic                     mac_neg_s1;

	logic signed [PW-1:0]     win_q [WIN_N];
	logic signed [CW-1:0]     wt_q [4];
	logic signed [CW-1:0]     dt_q [4];
	logic [14:0]              den_q;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [PW-1:0]     pos_q [3];
	logic signed [DNW-1:0]    vec_q [3];
	logic [DNW-1:0]           m_q [3];
	logic                     neg_q [3];
	logic [DDW-1:0]           len_q;
	logic signed [UW-1:0]     t_q [3];
	logic signed [UW-1:0]     n_q [3];
	logic signed [UW-1:0]     b_q [3];
	logic signed [UW-1:0]     prevb_q [3];

	logic                     out_valid_q;
	logic [1:0]               out_kind_q;
	logic [95:0]              out_data_q;
	logic                     out_last_q;

	// Window after a new point is written, and the point count that follows.
	logic signed [PW-1:0]     win_ld [WIN_N];
	logic [2:0]               held_base;
	logic [1:0]               slot;
	logic [3:0]               slot_base;
	logic [2:0]               held_ld;

	logic [SW-1:0]            s_eff;
	logic                     last_sample;
	logic [3:0]               widx;
	logic [1:0]               ci0;
	logic [1:0]               ci1;
	logic [1:0]               term_last;
	logic signed [UW-1:0]     seed [3];
	logic signed [PW-1:0]     mul_a;
	logic signed [PW-1:0]     mul_b;
	logic signed [2*PW-1:0]   mul_p;
	logic                     acc_neg;
	logic [ACCW-1:0]          acc_mag;
	logic [DNW-1:0]           or_v;
	div_req_t                 div_req;
	logic                     div_done;
	logic [DNW-1:0]           div_quo;
	sqrt_req_t                sqrt_req;
	logic                     sqrt_done;
	logic [DDW-1:0]           sqrt_root;
	logic signed [UW-1:0]     unit_res;
	logic [95:0]              emit_data;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// The sample count register is clamped to 1..MAX_SAMPLES before use.
	always_comb begin
		if (samples_q == '0) begin
			s_eff = SW'(1);
		end else if (int'(samples_q) > MAX_SAMPLES) begin
			s_eff = SW'(MAX_SAMPLES);
		end else begin
			s_eff = SW'(samples_q);
		end
	end

	assign last_sample = (j_q == s_eff - 1'b1);

	// A curve start clears the window before the point is placed. The point lands in the
	// slot after the last one held; a full window never occurs here, but the slot is clamped.
	always_comb begin
		win_ld = win_q;
		if (s_axis_tuser[0]) begin
			for (int i = 0; i < WIN_N; i++) begin
				win_ld[i] = '0;
			end
		end
		held_base = s_axis_tuser[0] ? 3'd0 : held_q;
		slot      = (held_base > 3'd3) ? 2'd3 : held_base[1:0];
		slot_base = 4'({slot, 1'b0}) + 4'(slot);
		win_ld[slot_base]        = s_axis_tdata[31:0];
		win_ld[slot_base + 4'd1] = s_axis_tdata[63:32];
		win_ld[slot_base + 4'd2] = s_axis_tdata[95:64];
		held_ld = 3'(slot) + 3'd1;
	end

	// Operand selection for the shared multiplier. Cross products take two terms per
	// component; the second is subtracted.
	assign widx = 4'({term_q, 1'b0}) + 4'(term_q) + 4'(comp_q);
	assign ci0  = nxt3(comp_q);
	assign ci1  = nxt3(ci0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			seed[i] = seeded_q ? prevb_q[i] : '0;
		end
		if (!seeded_q) begin
			seed[2] = ONE_Q14;
		end
	end

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		term_last = 2'd1;
		case (op_q)
			OP_POS: begin
				mul_a     = win_q[widx];
				mul_b     = PW'(wt_q[term_q]);
				term_last = 2'd3;
			end
			OP_TAN: begin
				mul_a     = win_q[widx];
				mul_b     = PW'(dt_q[term_q]);
				term_last = 2'd3;
			end
			OP_CRN: begin
				mul_a = (term_q == 2'd0) ? PW'(seed[ci0]) : PW'(seed[ci1]);
				mul_b = (term_q == 2'd0) ? PW'(t_q[ci1]) : PW'(t_q[ci0]);
			end
			OP_CRB: begin
				mul_a = (term_q == 2'd0) ? PW'(t_q[ci0]) : PW'(t_q[ci1]);
				mul_b = (term_q == 2'd0) ? PW'(n_q[ci1]) : PW'(n_q[ci0]);
			end
			OP_SQ: begin
				mul_a     = {1'b0, m_q[term_q][30:0]};
				mul_b     = {1'b0, m_q[term_q][30:0]};
				term_last = 2'd2;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	csfs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// The divider serves both the rounded position scaling and the unit-vector components.
	// Position rounds half away from zero: the magnitude is divided and the sign put back.
	assign acc_neg = acc_q[ACCW-1];
	assign acc_mag = acc_neg ? ACCW'(-acc_q) : ACCW'(acc_q);

	always_comb begin
		div_req.start = ((state_q == S_MACEND) && (op_q == OP_POS)) || (state_q == S_NDIV);
		if (state_q == S_NDIV) begin
			div_req.num = DNW'({m_q[comp_q][29:0], 14'b0}) + DNW'(len_q[DDW-1:1]);
			div_req.den = len_q;
		end else begin
			div_req.num = acc_mag[DNW-1:0] + DNW'(den_q[14:1]);
			div_req.den = DDW'(den_q);
		end
	end

	csfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done_q (div_done),
		.quo_q  (div_quo)
	);

	assign sqrt_req.start = (state_q == S_MACEND) && (op_q == OP_SQ);
	assign sqrt_req.rad   = acc_q;

	csfs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.done_q (sqrt_done),
		.root_q (sqrt_root)
	);

	assign unit_res = neg_q[comp_q] ? -div_quo[UW-1:0] : div_quo[UW-1:0];
	assign or_v     = m_q[0] | m_q[1] | m_q[2];

	always_comb begin
		case (emit_k_q)
			KIND_POS: emit_data = {pos_q[2], pos_q[1], pos_q[0]};
			KIND_TAN: emit_data = {PW'(t_q[2]), PW'(t_q[1]), PW'(t_q[0])};
			KIND_NRM: emit_data = {PW'(n_q[2]), PW'(n_q[1]), PW'(n_q[0])};
			default:  emit_data = {PW'(b_q[2]), PW'(b_q[1]), PW'(b_q[0])};
		endcase
	end

	// Main sequencer. Each sample runs: weights, three positions (sum and divide), the
	// tangent sum, then three normalizations (tangent, normal, binormal) with the cross
	// products between them, and finally four results into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_POS;
			comp_q      <= '0;
			term_q      <= '0;
			dst_q       <= DST_T;
			emit_k_q    <= KIND_POS;
			j_q         <= '0;
			kind_q      <= 1'b0;
			samples_q   <= SAMPLES_RST;
			held_q      <= '0;
			seeded_q    <= 1'b0;
			pneg_q      <= 1'b0;
			mac_v_s1    <= 1'b0;
			mac_neg_s1  <= 1'b0;
			win_q       <= '{default: '0};
			wt_q        <= '{default: '0};
			dt_q        <= '{default: '0};
			den_q       <= '0;
			acc_q       <= '0;
			pos_q       <= '{default: '0};
			vec_q       <= '{default: '0};
			m_q         <= '{default: '0};
			neg_q       <= '{default: 1'b0};
			len_q       <= '0;
			t_q         <= '{default: '0};
			n_q         <= '{default: '0};
			b_q         <= '{default: '0};
			prevb_q     <= '{default: '0};
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_POS;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CURVE_KIND: kind_q <= cfg_data[0];
					REG_SAMPLES:    samples_q <= cfg_data;
					default:        kind_q <= kind_q;
				endcase
			end

			// Products pass through the multiplier's product register before they reach the accumulator.
			mac_v_s1   <= (state_q == S_MAC);
			mac_neg_s1 <= (state_q == S_MAC) && (term_q == 2'd1) &&
			              ((op_q == OP_CRN) || (op_q == OP_CRB));
			if (mac_v_s1) begin
				acc_q <= mac_neg_s1 ? acc_q - mul_p : acc_q + mul_p;
			end

			// While results are being emitted the emit state refills the output register.
			if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						win_q  <= win_ld;
						held_q <= held_ld;
						if (s_axis_tuser[0]) begin
							prevb_q  <= '{default: '0};
							seeded_q <= 1'b0;
						end
						if (held_ld == 3'd4) begin
							j_q     <= '0;
							term_q  <= '0;
							state_q <= S_WGT;
						end
					end
				end
				// One control point's weights per cycle.
				S_WGT: begin
					wt_q[term_q] <= basis_coef(kind_q, 1'b0, term_q, 5'(j_q), 5'(s_eff));
					dt_q[term_q] <= basis_coef(kind_q, 1'b1, term_q, 5'(j_q), 5'(s_eff));
					den_q        <= seg_den(kind_q, 5'(s_eff));
					if (term_q == 2'd3) begin
						op_q    <= OP_POS;
						comp_q  <= '0;
						term_q  <= '0;
						acc_q   <= '0;
						state_q <= S_MAC;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end
				S_MAC: begin
					if (term_q == term_last) begin
						term_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_MACEND;
				end
				S_MACEND: begin
					case (op_q)
						OP_POS: begin
							pneg_q  <= acc_neg;
							state_q <= S_PDIVW;
						end
						OP_SQ: begin
							state_q <= S_NSQRT;
						end
						default: begin
							vec_q[comp_q] <= acc_q[DNW-1:0];
							if (comp_q != 2'd2) begin
								comp_q  <= comp_q + 2'd1;
								acc_q   <= '0;
								state_q <= S_MAC;
							end else begin
								comp_q  <= '0;
								state_q <= S_NABS;
								if (op_q == OP_TAN) begin
									dst_q <= DST_T;
								end else if (op_q == OP_CRN) begin
									dst_q <= DST_N;
								end else begin
									dst_q <= DST_B;
								end
							end
						end
					endcase
				end
				S_PDIVW: begin
					if (div_done) begin
						pos_q[comp_q] <= pneg_q ? -div_quo[PW-1:0] : div_quo[PW-1:0];
						acc_q         <= '0;
						state_q       <= S_MAC;
						if (comp_q != 2'd2) begin
							comp_q <= comp_q + 2'd1;
						end else begin
							comp_q <= '0;
							op_q   <= OP_TAN;
						end
					end
				end
				S_NABS: begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec_q[i][DNW-1];
						m_q[i]   <= vec_q[i][DNW-1] ? DNW'(-vec_q[i]) : DNW'(vec_q[i]);
					end
					state_q <= S_NSHIFT;
				end
				// Bring the largest magnitude's top bit to bit 29, one bit per cycle.
				S_NSHIFT: begin
					if (or_v == '0) begin
						// A zero vector normalizes to zero.
						case (dst_q)
							DST_T:   t_q <= '{default: '0};
							DST_N:   n_q <= '{default: '0};
							default: b_q <= '{default: '0};
						endcase
						state_q <= S_NFIN;
					end else if (|or_v[DNW-1:30]) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] >> 1;
						end
					end else if (!or_v[29]) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 1;
						end
					end else begin
						op_q    <= OP_SQ;
						term_q  <= '0;
						acc_q   <= '0;
						state_q <= S_MAC;
					end
				end
				S_NSQRT: begin
					if (sqrt_done) begin
						len_q   <= sqrt_root;
						comp_q  <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					state_q <= S_NDIVW;
				end
				S_NDIVW: begin
					if (div_done) begin
						case (dst_q)
							DST_T:   t_q[comp_q] <= unit_res;
							DST_N:   n_q[comp_q] <= unit_res;
							default: b_q[comp_q] <= unit_res;
						endcase
						if (comp_q != 2'd2) begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_NDIV;
						end else begin
							comp_q  <= '0;
							state_q <= S_NFIN;
						end
					end
				end
				S_NFIN: begin
					comp_q <= '0;
					term_q <= '0;
					acc_q  <= '0;
					case (dst_q)
						DST_T: begin
							op_q    <= OP_CRN;
							state_q <= S_MAC;
						end
						DST_N: begin
							op_q    <= OP_CRB;
							state_q <= S_MAC;
						end
						default: begin
							prevb_q  <= b_q;
							seeded_q <= 1'b1;
							emit_k_q <= KIND_POS;
							state_q  <= S_EMIT;
						end
					endcase
				end
				// Results go out as position, tangent, normal, binormal.
				S_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= emit_k_q;
						out_data_q  <= emit_data;
						out_last_q  <= (emit_k_q == KIND_BIN) && last_sample;
						emit_k_q    <= emit_k_q + 2'd1;
						if (emit_k_q == KIND_BIN) begin
							if (last_sample) begin
								state_q <= S_IDLE;
								if (kind_q) begin
									// B-spline: slide the window by one point.
									for (int i = 0; i < 9; i++) begin
										win_q[i] <= win_q[i + 3];
									end
									for (int i = 9; i < WIN_N; i++) begin
										win_q[i] <= '0;
									end
									held_q <= 3'd3;
								end else begin
									// Bezier: the end point starts the next segment.
									for (int i = 0; i < 3; i++) begin
										win_q[i] <= win_q[i + 9];
									end
									for (int i = 3; i < WIN_N; i++) begin
										win_q[i] <= '0;
									end
									held_q <= 3'd1;
								end
							end else begin
								j_q     <= j_q + 1'b1;
								term_q  <= '0;
								state_q <= S_WGT;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/csfs_checker.sv]
// Port-level checks of the cubic spline frame sampler and their binding to the top level.
module csfs_sva_checker import csfs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Unit vectors stay within plus and minus one in Q2.14.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_POS) |->
		($signed(m_axis_tdata[31:0]) >= -32'sd16384) &&
		($signed(m_axis_tdata[31:0]) <= 32'sd16384) &&
		($signed(m_axis_tdata[63:32]) >= -32'sd16384) &&
		($signed(m_axis_tdata[63:32]) <= 32'sd16384) &&
		($signed(m_axis_tdata[95:64]) >= -32'sd16384) &&
		($signed(m_axis_tdata[95:64]) <= 32'sd16384))
		else $error("unit vector component out of range");

	// The last result of a point is always a binormal.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_BIN)
		else $error("last result is not a binormal");

	// Inside a sample the block does not take a new point.
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready &&
		((m_axis_tuser == KIND_POS) || (m_axis_tuser == KIND_TAN)) |=> !s_axis_tready)
		else $error("point taken in the middle of a sample");

endmodule

bind cubic_spline_frame_sampler csfs_sva_checker u_csfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
